[hdl/asd_pkg.sv]
// Shared constants and types for the accelerometer stillness detector.
package asd_pkg;
	localparam int WINDOW_LEN = 32;
	localparam int JUDGE_LEN  = 16;
	localparam int WIN_AW     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int JUD_AW     = (JUDGE_LEN > 1) ? $clog2(JUDGE_LEN) : 1;
	localparam int JUD_CW     = $clog2(JUDGE_LEN + 1);
	localparam int WIN_SH     = $clog2(WINDOW_LEN);
	localparam int SUM_W      = 15 + WIN_AW + 1;
	localparam int SQ_W       = 30 + WIN_AW + 1;
	localparam int VAR_W      = SQ_W + WIN_AW + 2;
	localparam int TOT_W      = 2 * VAR_W + 2;
	// variance is squared in halves: low part width, high part is the rest
	localparam int VAR_LO     = (VAR_W + 1) / 2;

	localparam logic [6:0]  LPF_RATIO_RST = 7'd50;
	localparam logic [27:0] MOTION_THR_RST = 28'd5000;

	typedef enum logic [1:0] {
		CFG_LPF_RATIO = 2'd0,
		CFG_MOTION_THRESHOLD = 2'd1
	} cfg_idx_t;

	typedef logic signed [14:0] mg_t;

	typedef struct packed {
		logic [6:0]  lpf_ratio;
		logic [27:0] motion_threshold;
	} cfg_t;
endpackage

[hdl/asd_ring_ram.sv]
// Sample ring memory: one write port, one registered read port.
module asd_ring_ram
	import asd_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [WIN_AW-1:0] waddr,
	input  logic [44:0]       wdata,
	input  logic [WIN_AW-1:0] raddr,
	output logic [44:0]       rdata
);
	logic [44:0] mem [WINDOW_LEN];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[hdl/accel_stillness_detector_unit.sv]
// Top level of the accelerometer stillness detector.
// A new sample is accepted only in idle, after the previous result has been handed off.
// Each sample is processed by the sequencer that walks the ring reads, the shared filter
// divider (one quotient bit per cycle) and the shared 22x22 multiplier (three partial
// products per axis).
// Reset: asynchronous, active low; after reset a clearing pass zeroes the sample
// ring before input opens.
module accel_stillness_detector_unit
	import asd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  mg_t         accel_x,
	input  mg_t         accel_y,
	input  mg_t         accel_z,
	output logic        out_valid,
	input  logic        out_stall,
	output mg_t         filtered_x,
	output mg_t         filtered_y,
	output mg_t         filtered_z,
	output mg_t         mean_x,
	output mg_t         mean_y,
	output mg_t         mean_z,
	output logic        moving_now,
	output logic        judge_full,
	output logic        still_weight,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [27:0] cfg_data
);
	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_RDOLD, S_FILT, S_DIV, S_UPD, S_VAR, S_SQ, S_THR, S_DONE
	} st_t;

	st_t st_q;
	cfg_t cfg_q;
	logic [WIN_AW-1:0] pos_q, clr_q;
	logic [1:0] ax_q;
	logic [1:0] pc_q;
	logic [4:0] bit_q;
	mg_t in_q [3];
	mg_t f_q [3];
	mg_t prev_q [3];
	logic signed [SUM_W-1:0] sum_q [3];
	logic signed [SQ_W-1:0] ssq_q [3];
	logic [VAR_W-1:0] var_q;
	logic [TOT_W-1:0] tot_q;
	logic [JUDGE_LEN-1:0] jb_q;
	logic [JUD_AW-1:0] jp_q;
	logic [JUD_CW-1:0] jc_q;
	logic wrap_q, weight_q, mov_q;
	// divider state: numerator magnitude, remainder, quotient, sign
	logic [21:0] num_q;
	logic [21:0] rem_q;
	logic [14:0] quo_q;
	logic neg_q;

	logic we;
	logic [WIN_AW-1:0] waddr, raddr;
	logic [44:0] wdata, rdata;
	asd_ring_ram u_ram (.clk, .we, .waddr, .wdata, .raddr, .rdata);

	logic [WIN_AW-1:0] nxt;
	assign nxt = pos_q + 1'b1;
	logic [6:0] r_eff;
	assign r_eff = (cfg_q.lpf_ratio == 7'd0) ? 7'd1 : cfg_q.lpf_ratio;

	// result handoff: done step loads the output register when it is free
	logic fire;
	assign fire = (st_q == S_DONE) && (!out_valid || !out_stall);

	// ring access: clear sweep, read cur up to FILT, then read old entry at nxt and overwrite it in UPD
	always_comb begin
		we = 1'b0; waddr = nxt; wdata = {f_q[2], f_q[1], f_q[0]};
		raddr = (st_q == S_IDLE || st_q == S_RDOLD) ? pos_q : nxt;
		if (st_q == S_CLR) begin
			we = 1'b1; waddr = clr_q; wdata = '0;
		end else if (st_q == S_UPD && ax_q == 2'd0) we = 1'b1;
	end

	// shared multiplier: squares the variance from its two halves
	logic [VAR_LO-1:0] ma, mb;
	logic [2*VAR_LO-1:0] mp;
	assign mp = ma * mb;

	always_comb begin
		case (pc_q)
			2'd0: begin
				ma = var_q[VAR_LO-1:0]; mb = var_q[VAR_LO-1:0];
			end
			2'd1: begin
				ma = VAR_LO'(var_q[VAR_W-1:VAR_LO]); mb = var_q[VAR_LO-1:0];
			end
			default: begin
				ma = VAR_LO'(var_q[VAR_W-1:VAR_LO]); mb = VAR_LO'(var_q[VAR_W-1:VAR_LO]);
			end
		endcase
	end

	logic signed [21:0] fnum;
	assign fnum = 22'(prev_q[ax_q]) * 22'($signed({1'b0, r_eff - 7'd1}))
		+ 22'(in_q[ax_q]);

	// variance numerator for current axis
	logic signed [VAR_W:0] vnum;
	logic signed [2*SUM_W-1:0] s2;
	assign s2 = sum_q[ax_q] * sum_q[ax_q];
	assign vnum = ((VAR_W+1)'(ssq_q[ax_q]) <<< WIN_SH) - (VAR_W+1)'(s2);

	// limit = (thr*N^2)^2 = thr^2 * N^4
	logic [55:0] thr2;
	assign thr2 = cfg_q.motion_threshold * cfg_q.motion_threshold;

	logic [22:0] trial;
	assign trial = {rem_q, num_q[21]} - {16'd0, r_eff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR; clr_q <= '0; pos_q <= '0; ax_q <= '0; bit_q <= '0;
			pc_q <= '0;
			cfg_q <= '{lpf_ratio: LPF_RATIO_RST, motion_threshold: MOTION_THR_RST};
			for (int a = 0; a < 3; a++) begin
				sum_q[a] <= '0; ssq_q[a] <= '0;
			end
			jb_q <= '1; jp_q <= '0; jc_q <= JUD_CW'(JUDGE_LEN);
			wrap_q <= 1'b0; weight_q <= 1'b1; mov_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_LPF_RATIO: cfg_q.lpf_ratio <= cfg_data[6:0];
					CFG_MOTION_THRESHOLD: cfg_q.motion_threshold <= cfg_data;
					default: ;
				endcase
			end
			if (fire) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			case (st_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == WIN_AW'(WINDOW_LEN - 1)) st_q <= S_IDLE;
				end
				S_IDLE: if (in_valid) begin
					in_q[0] <= accel_x; in_q[1] <= accel_y; in_q[2] <= accel_z;
					st_q <= S_RDOLD;
				end
				S_RDOLD: st_q <= S_FILT;
				S_FILT: begin
					// rdata holds entry at cur
					prev_q[0] <= rdata[14:0]; prev_q[1] <= rdata[29:15];
					prev_q[2] <= rdata[44:30];
					ax_q <= '0; bit_q <= '0; rem_q <= '0; st_q <= S_DIV;
				end
				S_DIV: begin
					if (bit_q == 5'd0) begin
						neg_q <= fnum[21];
						num_q <= fnum[21] ? 22'(-fnum) : fnum;
						rem_q <= '0; bit_q <= 5'd1;
					end else begin
						num_q <= num_q << 1;
						if (!trial[22]) begin
							rem_q <= trial[21:0]; quo_q <= {quo_q[13:0], 1'b1};
						end else begin
							rem_q <= {rem_q[20:0], num_q[21]}; quo_q <= {quo_q[13:0], 1'b0};
						end
						if (bit_q == 5'd22) begin
							bit_q <= '0;
							f_q[ax_q] <= neg_q
								? -({quo_q[13:0], !trial[22]})
								: {quo_q[13:0], !trial[22]};
							if (ax_q == 2'd2) begin
								ax_q <= '0; st_q <= S_UPD;
							end else ax_q <= ax_q + 1'b1;
						end else bit_q <= bit_q + 1'b1;
					end
				end
				S_UPD: begin
					// rdata now holds entry at nxt (old value)
					if (ax_q == 2'd0) begin
						prev_q[0] <= rdata[14:0]; prev_q[1] <= rdata[29:15];
						prev_q[2] <= rdata[44:30]; ax_q <= 2'd3;
					end else begin
						ax_q <= 2'd0; st_q <= S_VAR; pos_q <= nxt;
						for (int a = 0; a < 3; a++) begin
							sum_q[a] <= sum_q[a] + SUM_W'(f_q[a]) - SUM_W'(prev_q[a]);
							ssq_q[a] <= ssq_q[a] + SQ_W'(30'(f_q[a]) * 30'(f_q[a]))
								- SQ_W'(30'(prev_q[a]) * 30'(prev_q[a]));
						end
						tot_q <= '0;
					end
				end
				S_VAR: begin
					var_q <= vnum[VAR_W] ? '0 : vnum[VAR_W-1:0];
					st_q <= S_SQ;
				end
				// lo*lo, 2*hi*lo, hi*hi accumulated in turn
				S_SQ: begin
					case (pc_q)
						2'd0: tot_q <= tot_q + TOT_W'(mp);
						2'd1: tot_q <= tot_q + (TOT_W'(mp) << (VAR_LO + 1));
						default: tot_q <= tot_q + (TOT_W'(mp) << (2 * VAR_LO));
					endcase
					if (pc_q == 2'd2) begin
						pc_q <= '0;
						if (ax_q == 2'd2) st_q <= S_THR;
						else begin
							ax_q <= ax_q + 1'b1; st_q <= S_VAR;
						end
					end else pc_q <= pc_q + 1'b1;
				end
				S_THR: begin
					mov_q <= (tot_q > (TOT_W'(thr2) << (4 * WIN_SH)));
					st_q <= S_DONE;
				end
				S_DONE: if (fire) begin
					jc_q <= jc_q - JUD_CW'(jb_q[jp_q]) + JUD_CW'(mov_q);
					jb_q[jp_q] <= mov_q;
					if (jp_q == JUD_AW'(JUDGE_LEN - 1)) begin
						jp_q <= '0; wrap_q <= 1'b1;
						weight_q <= ((jc_q - JUD_CW'(jb_q[jp_q]) + JUD_CW'(mov_q)) == '0);
					end else begin
						jp_q <= jp_q + 1'b1;
						if (wrap_q)
							weight_q <= ((jc_q - JUD_CW'(jb_q[jp_q]) + JUD_CW'(mov_q)) == '0);
					end
					for (int a = 0; a < 3; a++) prev_q[a] <= f_q[a];
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (fire) begin
			filtered_x <= f_q[0]; filtered_y <= f_q[1]; filtered_z <= f_q[2];
			mean_x <= 15'(sum_q[0] / WINDOW_LEN);
			mean_y <= 15'(sum_q[1] / WINDOW_LEN);
			mean_z <= 15'(sum_q[2] / WINDOW_LEN);
			moving_now <= mov_q;
		end
	end
	assign judge_full = wrap_q;
	assign still_weight = weight_q;

	assign in_stall = (st_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// no beat accepted outside idle
	a_acc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> (st_q == S_IDLE)) else $error("accept outside idle");
	// result follows the done step
	a_out_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(st_q) == S_DONE) else $error("stray result");
	// judge count bounded
	a_jc: assert property (@(posedge clk) disable iff (!arst_n)
		jc_q <= JUD_CW'(JUDGE_LEN)) else $error("judge count overflow");
endmodule
